// ===== rtl/cmc_pkg.sv =====
// ----------------------------------------------------------------------------
// cmc_pkg: shared types and constants for the color mask centroid block
// Pixel and result formats, register map, controller states and defaults.
// ----------------------------------------------------------------------------
package cmc_pkg;

	// frame geometry defaults
	localparam int MAX_COLS_DEF = 1024;
	localparam int MAX_ROWS_DEF = 1024;

	// fixed field widths
	localparam int CH_W    = 8;
	localparam int CNT_W   = 21;
	localparam int SUM_W   = 30;
	localparam int LW_W    = 11;
	localparam int CEN_W   = 10;
	localparam int IDX_W   = 3;
	localparam int CFG_W   = 21;
	localparam int STEP_W  = $clog2(SUM_W);

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
	localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};

	// register map
	localparam logic [IDX_W-1:0] REG_HUE_MIN    = 3'd0;
	localparam logic [IDX_W-1:0] REG_HUE_MAX    = 3'd1;
	localparam logic [IDX_W-1:0] REG_SAT_MIN    = 3'd2;
	localparam logic [IDX_W-1:0] REG_SAT_MAX    = 3'd3;
	localparam logic [IDX_W-1:0] REG_VAL_MIN    = 3'd4;
	localparam logic [IDX_W-1:0] REG_VAL_MAX    = 3'd5;
	localparam logic [IDX_W-1:0] REG_MIN_COUNT  = 3'd6;
	localparam logic [IDX_W-1:0] REG_LINE_WIDTH = 3'd7;

	// register reset values
	localparam logic [CH_W-1:0]  HUE_MIN_RST    = 8'd0;
	localparam logic [CH_W-1:0]  HUE_MAX_RST    = 8'd255;
	localparam logic [CH_W-1:0]  SAT_MIN_RST    = 8'd0;
	localparam logic [CH_W-1:0]  SAT_MAX_RST    = 8'd255;
	localparam logic [CH_W-1:0]  VAL_MIN_RST    = 8'd225;
	localparam logic [CH_W-1:0]  VAL_MAX_RST    = 8'd255;
	localparam logic [CNT_W-1:0] MIN_COUNT_RST  = 21'd15;
	localparam logic [LW_W-1:0]  LINE_WIDTH_RST = 11'd640;

	typedef struct packed {
		logic [CH_W-1:0] hue;
		logic [CH_W-1:0] saturation;
		logic [CH_W-1:0] brightness;
		logic            frame_end;
	} pixel_t;

	typedef struct packed {
		logic [CEN_W-1:0] centroid_col;
		logic [CEN_W-1:0] centroid_row;
		logic             found;
		logic [CNT_W-1:0] pixel_total;
	} result_t;

	// controller to datapath commands
	typedef struct packed {
		logic acc_en;      // pixel request taken, accumulate it
		logic frame_done;  // frame-end pixel: load dividers, clear accumulators
		logic div_step;    // one quotient bit
		logic res_load;    // capture result into output register
	} cmd_t;

	typedef enum logic [1:0] {
		ST_ACCUM,
		ST_DIVIDE,
		ST_WRITE
	} state_t;

endpackage

// ===== rtl/cmc_div.sv =====
// ----------------------------------------------------------------------------
// cmc_div: restoring divider, one quotient bit per step
// Dividend shifts out at the top while quotient bits shift in at the bottom.
// ----------------------------------------------------------------------------
module cmc_div (
	input  logic                      clk,
	input  logic                      load,
	input  logic                      step,
	input  logic [cmc_pkg::SUM_W-1:0] dividend,
	input  logic [cmc_pkg::CNT_W-1:0] divisor,
	output logic [cmc_pkg::SUM_W-1:0] quotient
);

	logic [cmc_pkg::CNT_W-1:0] rem_q;
	logic [cmc_pkg::SUM_W-1:0] dq_q;
	logic [cmc_pkg::CNT_W:0]   trial;
	logic [cmc_pkg::CNT_W+1:0] diff;
	logic                      ge;

	// trial subtract of the divisor from the shifted remainder
	always_comb begin
		trial = {rem_q, dq_q[cmc_pkg::SUM_W-1]};
		diff  = {1'b0, trial} - {2'b00, divisor};
		ge    = ~diff[cmc_pkg::CNT_W+1];
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= '0;
			dq_q  <= dividend;
		end else if (step) begin
			rem_q <= ge ? diff[cmc_pkg::CNT_W-1:0] : trial[cmc_pkg::CNT_W-1:0];
			dq_q  <= {dq_q[cmc_pkg::SUM_W-2:0], ge};
		end
	end

	assign quotient = dq_q;

endmodule

// ===== rtl/cmc_dp.sv =====
// ----------------------------------------------------------------------------
// cmc_dp: color mask centroid datapath
// Config registers, threshold test, position counters, accumulators,
// two dividers and the result register.
// ----------------------------------------------------------------------------
module cmc_dp #(
	parameter int MAX_COLS = cmc_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = cmc_pkg::MAX_ROWS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [cmc_pkg::IDX_W-1:0] cfg_index,
	input  logic [cmc_pkg::CFG_W-1:0] cfg_data,
	input  cmc_pkg::pixel_t           pixel,
	input  cmc_pkg::cmd_t             cmd,
	output cmc_pkg::result_t          result
);

	localparam int CW = $clog2(MAX_COLS);
	localparam int RW = $clog2(MAX_ROWS);
	// compare width wide enough for column+1, MAX_COLS and line_width
	localparam int NW = (CW + 1 > cmc_pkg::LW_W) ? CW + 1 : cmc_pkg::LW_W;
	localparam logic [NW-1:0] COLS_LIM = NW'(MAX_COLS);
	localparam logic [RW-1:0] ROW_LAST = RW'(MAX_ROWS - 1);

	logic [cmc_pkg::CH_W-1:0]  hue_min_q, hue_max_q, sat_min_q, sat_max_q;
	logic [cmc_pkg::CH_W-1:0]  val_min_q, val_max_q;
	logic [cmc_pkg::CNT_W-1:0] min_count_q;
	logic [cmc_pkg::LW_W-1:0]  line_width_q;

	logic [CW-1:0]             col_q;
	logic [RW-1:0]             row_q;
	logic [cmc_pkg::CNT_W-1:0] count_q;
	logic [cmc_pkg::SUM_W-1:0] col_sum_q, row_sum_q;

	logic                      sel;
	logic [cmc_pkg::CNT_W-1:0] count_nxt;
	logic [cmc_pkg::SUM_W:0]   col_add, row_add;
	logic [cmc_pkg::SUM_W-1:0] col_sum_nxt, row_sum_nxt;
	logic [NW-1:0]             col_inc;
	logic                      wrap;

	logic [cmc_pkg::CNT_W-1:0] total_q;
	logic                      found_q;
	logic [cmc_pkg::SUM_W-1:0] col_quo, row_quo;
	cmc_pkg::result_t          res_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_min_q    <= cmc_pkg::HUE_MIN_RST;
			hue_max_q    <= cmc_pkg::HUE_MAX_RST;
			sat_min_q    <= cmc_pkg::SAT_MIN_RST;
			sat_max_q    <= cmc_pkg::SAT_MAX_RST;
			val_min_q    <= cmc_pkg::VAL_MIN_RST;
			val_max_q    <= cmc_pkg::VAL_MAX_RST;
			min_count_q  <= cmc_pkg::MIN_COUNT_RST;
			line_width_q <= cmc_pkg::LINE_WIDTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cmc_pkg::REG_HUE_MIN:    hue_min_q    <= cfg_data[cmc_pkg::CH_W-1:0];
				cmc_pkg::REG_HUE_MAX:    hue_max_q    <= cfg_data[cmc_pkg::CH_W-1:0];
				cmc_pkg::REG_SAT_MIN:    sat_min_q    <= cfg_data[cmc_pkg::CH_W-1:0];
				cmc_pkg::REG_SAT_MAX:    sat_max_q    <= cfg_data[cmc_pkg::CH_W-1:0];
				cmc_pkg::REG_VAL_MIN:    val_min_q    <= cfg_data[cmc_pkg::CH_W-1:0];
				cmc_pkg::REG_VAL_MAX:    val_max_q    <= cfg_data[cmc_pkg::CH_W-1:0];
				cmc_pkg::REG_MIN_COUNT:  min_count_q  <= cfg_data[cmc_pkg::CNT_W-1:0];
				cmc_pkg::REG_LINE_WIDTH: line_width_q <= cfg_data[cmc_pkg::LW_W-1:0];
				default: ;
			endcase
		end
	end

	// threshold test and saturating accumulate
	always_comb begin
		sel = (pixel.hue >= hue_min_q) && (pixel.hue <= hue_max_q) &&
		      (pixel.saturation >= sat_min_q) && (pixel.saturation <= sat_max_q) &&
		      (pixel.brightness >= val_min_q) && (pixel.brightness <= val_max_q) &&
		      (count_q != cmc_pkg::COUNT_MAX);

		col_add = {1'b0, col_sum_q} + (cmc_pkg::SUM_W+1)'(col_q);
		row_add = {1'b0, row_sum_q} + (cmc_pkg::SUM_W+1)'(row_q);

		if (sel) begin
			count_nxt   = count_q + 1'b1;
			col_sum_nxt = col_add[cmc_pkg::SUM_W] ? cmc_pkg::SUM_MAX
			                                      : col_add[cmc_pkg::SUM_W-1:0];
			row_sum_nxt = row_add[cmc_pkg::SUM_W] ? cmc_pkg::SUM_MAX
			                                      : row_add[cmc_pkg::SUM_W-1:0];
		end else begin
			count_nxt   = count_q;
			col_sum_nxt = col_sum_q;
			row_sum_nxt = row_sum_q;
		end

		// column wraps at line width or at the column limit
		col_inc = NW'(col_q) + 1'b1;
		wrap    = (col_inc >= NW'(line_width_q)) || (col_inc >= COLS_LIM);
	end

	// position counters and accumulators, cleared at frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			count_q   <= '0;
			col_sum_q <= '0;
			row_sum_q <= '0;
		end else if (cmd.frame_done) begin
			col_q     <= '0;
			row_q     <= '0;
			count_q   <= '0;
			col_sum_q <= '0;
			row_sum_q <= '0;
		end else if (cmd.acc_en) begin
			count_q   <= count_nxt;
			col_sum_q <= col_sum_nxt;
			row_sum_q <= row_sum_nxt;
			if (wrap) begin
				col_q <= '0;
				if (row_q != ROW_LAST)
					row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_inc[CW-1:0];
			end
		end
	end

	// frame totals held for the divide
	always_ff @(posedge clk) begin
		if (cmd.frame_done) begin
			total_q <= count_nxt;
			found_q <= count_nxt > min_count_q;
		end
	end

	cmc_div u_div_col (
		.clk      (clk),
		.load     (cmd.frame_done),
		.step     (cmd.div_step),
		.dividend (col_sum_nxt),
		.divisor  (total_q),
		.quotient (col_quo)
	);

	cmc_div u_div_row (
		.clk      (clk),
		.load     (cmd.frame_done),
		.step     (cmd.div_step),
		.dividend (row_sum_nxt),
		.divisor  (total_q),
		.quotient (row_quo)
	);

	// result register
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_q.centroid_col <= found_q ? col_quo[cmc_pkg::CEN_W-1:0] : '0;
			res_q.centroid_row <= found_q ? row_quo[cmc_pkg::CEN_W-1:0] : '0;
			res_q.found        <= found_q;
			res_q.pixel_total  <= total_q;
		end
	end

	assign result = res_q;

endmodule

// ===== rtl/cmc_ctrl.sv =====
// ----------------------------------------------------------------------------
// cmc_ctrl: color mask centroid controller
// Sequences accumulate, divide and result write; owns both handshakes.
// ----------------------------------------------------------------------------
module cmc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pixel_valid,
	input  logic          frame_end,
	output logic          pixel_stall,
	output logic          result_valid,
	input  logic          result_stall,
	output cmc_pkg::cmd_t cmd
);

	cmc_pkg::state_t            state_q, state_nxt;
	logic [cmc_pkg::STEP_W-1:0] step_q;
	logic                       res_valid_q;
	logic                       out_free;

	// state register, divide step counter, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cmc_pkg::ST_ACCUM;
			step_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.frame_done)
				step_q <= cmc_pkg::STEP_W'(cmc_pkg::SUM_W - 1);
			else if (cmd.div_step)
				step_q <= step_q - 1'b1;
			if (cmd.res_load)
				res_valid_q <= 1'b1;
			else if (!result_stall)
				res_valid_q <= 1'b0;
		end
	end

	// next state and commands
	always_comb begin
		state_nxt    = state_q;
		cmd          = '0;
		pixel_stall  = 1'b1;
		out_free     = !res_valid_q || !result_stall;
		unique case (state_q)
			cmc_pkg::ST_ACCUM: begin
				pixel_stall    = 1'b0;
				cmd.acc_en     = pixel_valid;
				cmd.frame_done = pixel_valid && frame_end;
				if (cmd.frame_done)
					state_nxt = cmc_pkg::ST_DIVIDE;
			end
			cmc_pkg::ST_DIVIDE: begin
				cmd.div_step = 1'b1;
				if (step_q == '0)
					state_nxt = cmc_pkg::ST_WRITE;
			end
			cmc_pkg::ST_WRITE: begin
				cmd.res_load = out_free;
				if (out_free)
					state_nxt = cmc_pkg::ST_ACCUM;
			end
			default: state_nxt = cmc_pkg::ST_ACCUM;
		endcase
	end

	assign result_valid = res_valid_q;

endmodule

// ===== rtl/color_mask_centroid.sv =====
// ----------------------------------------------------------------------------
// color_mask_centroid: centroid of HSV-thresholded pixels per frame
// Counts pixels inside the hue/saturation/value window, sums their
// positions and divides at frame end.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------
//  pixel    | pixel_valid / pixel_stall  | cmc_pkg::pixel_t  (in)
//  result   | result_valid / result_stall| cmc_pkg::result_t (out)
//  config   | cfg_we                     | cfg_index, cfg_data (in)
//
// One pixel per clock while accumulating. The frame-end pixel starts two
// bit-serial dividers (one quotient bit a cycle), followed by a write state;
// the pixel input stalls through both, so no pixel is taken before the write.
// The write state waits while the output register holds an untaken result.
// Reset loads register defaults and clears counters; there is no clearing pass.
//
module color_mask_centroid #(
	parameter int MAX_COLS = cmc_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = cmc_pkg::MAX_ROWS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [cmc_pkg::IDX_W-1:0] cfg_index,
	input  logic [cmc_pkg::CFG_W-1:0] cfg_data,
	input  logic                      pixel_valid,
	output logic                      pixel_stall,
	input  cmc_pkg::pixel_t           pixel,
	output logic                      result_valid,
	input  logic                      result_stall,
	output cmc_pkg::result_t          result
);

	cmc_pkg::cmd_t cmd;

	cmc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.frame_end    (pixel.frame_end),
		.pixel_stall  (pixel_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd)
	);

	cmc_dp #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixel     (pixel),
		.cmd       (cmd),
		.result    (result)
	);

	// a not-found result carries a zero centroid
	a_zero_when_lost: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.found |->
			result.centroid_col == '0 && result.centroid_row == '0)
		else $error("centroid nonzero without found");

	// found needs at least one selected pixel
	a_found_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.found |-> result.pixel_total != '0)
		else $error("found with empty pixel total");

	// the frame-end pixel request holds off the next one during the divide
	a_divide_stall: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && !pixel_stall && pixel.frame_end |=> pixel_stall)
		else $error("pixel taken during divide");

endmodule

// ===== tb/sv/color_mask_centroid_test.sv =====
// ----------------------------------------------------------------------------
// color_mask_centroid_test: self-checking bench for the color mask centroid
// Streams HSV pixel requests through the block under varied threshold and
// line width settings, predicts every frame result and compares it field by
// field. Short directed table first, then random frames with random idling
// on both channels and one long output hold to back the pipeline up.
// ----------------------------------------------------------------------------
module color_mask_centroid_test;

	localparam int COLS         = cmc_pkg::MAX_COLS_DEF;
	localparam int ROWS         = cmc_pkg::MAX_ROWS_DEF;
	localparam int DRAIN        = 48;      // divide, write and some margin
	localparam int HOLD_CYCLES  = 400;
	localparam int RANDOM_ITEMS = 720;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int MAX_LINES    = 100;

	// one row of the directed table: a register write or a pixel request
	typedef struct packed {
		bit                        is_reg;
		logic [cmc_pkg::IDX_W-1:0] reg_idx;
		logic [cmc_pkg::CFG_W-1:0] reg_val;
		cmc_pkg::pixel_t           px;
		bit                        typed;
		cmc_pkg::result_t          want;
	} plan_row_t;

	logic                      clk          = 1'b0;
	logic                      arst_n       = 1'b0;
	logic                      cfg_we       = 1'b0;
	logic [cmc_pkg::IDX_W-1:0] cfg_index    = '0;
	logic [cmc_pkg::CFG_W-1:0] cfg_data     = '0;
	logic                      pixel_valid  = 1'b0;
	logic                      pixel_stall;
	cmc_pkg::pixel_t           pixel        = '0;
	logic                      result_valid;
	logic                      result_stall = 1'b0;
	cmc_pkg::result_t          result;

	// register copies
	logic [cmc_pkg::CH_W-1:0]  hue_lo      = cmc_pkg::HUE_MIN_RST;
	logic [cmc_pkg::CH_W-1:0]  hue_hi      = cmc_pkg::HUE_MAX_RST;
	logic [cmc_pkg::CH_W-1:0]  sat_lo      = cmc_pkg::SAT_MIN_RST;
	logic [cmc_pkg::CH_W-1:0]  sat_hi      = cmc_pkg::SAT_MAX_RST;
	logic [cmc_pkg::CH_W-1:0]  val_lo      = cmc_pkg::VAL_MIN_RST;
	logic [cmc_pkg::CH_W-1:0]  val_hi      = cmc_pkg::VAL_MAX_RST;
	logic [cmc_pkg::CNT_W-1:0] count_floor = cmc_pkg::MIN_COUNT_RST;
	logic [cmc_pkg::LW_W-1:0]  row_len     = cmc_pkg::LINE_WIDTH_RST;

	// frame accumulation state
	logic [cmc_pkg::CEN_W-1:0] col_pos   = '0;
	logic [cmc_pkg::CEN_W-1:0] row_pos   = '0;
	logic [cmc_pkg::CNT_W-1:0] sel_count = '0;
	logic [cmc_pkg::SUM_W-1:0] col_acc   = '0;
	logic [cmc_pkg::SUM_W-1:0] row_acc   = '0;

	cmc_pkg::result_t centroid_q[$];
	plan_row_t        plan_q[$];
	cmc_pkg::result_t oldest;
	int unsigned      errors      = 0;
	int unsigned      cycles      = 0;
	int unsigned      pixels_sent = 0;
	bit               burst       = 1'b0;

	// output hold control
	int unsigned hold_reqs   = 0;
	int unsigned holds_taken = 0;
	int unsigned stall_left  = 0;
	int unsigned calm_left   = 0;
	int unsigned stall_roll;

	color_mask_centroid #(
		.MAX_COLS(COLS),
		.MAX_ROWS(ROWS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.pixel        (pixel),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic flag_error(input string msg);
		if (errors < MAX_LINES)
			$display("ERROR cycle %0d: %s", cycles, msg);
		errors++;
	endtask

	// table builders
	function automatic void plan_reg(input logic [cmc_pkg::IDX_W-1:0] idx,
		input int unsigned val);
		plan_row_t r;
		r         = '0;
		r.is_reg  = 1'b1;
		r.reg_idx = idx;
		r.reg_val = val[cmc_pkg::CFG_W-1:0];
		plan_q.insert(plan_q.size(), r);
	endfunction

	function automatic void plan_px(input int unsigned h, s, v, input bit last);
		plan_row_t r;
		r              = '0;
		r.px.hue        = h[cmc_pkg::CH_W-1:0];
		r.px.saturation = s[cmc_pkg::CH_W-1:0];
		r.px.brightness = v[cmc_pkg::CH_W-1:0];
		r.px.frame_end  = last;
		plan_q.insert(plan_q.size(), r);
	endfunction

	// frame-end pixel with its result written out
	function automatic void plan_want(input int unsigned h, s, v, cx, cy, f, total);
		plan_row_t r;
		r                   = '0;
		r.px.hue            = h[cmc_pkg::CH_W-1:0];
		r.px.saturation     = s[cmc_pkg::CH_W-1:0];
		r.px.brightness     = v[cmc_pkg::CH_W-1:0];
		r.px.frame_end      = 1'b1;
		r.typed             = 1'b1;
		r.want.centroid_col = cx[cmc_pkg::CEN_W-1:0];
		r.want.centroid_row = cy[cmc_pkg::CEN_W-1:0];
		r.want.found        = f[0];
		r.want.pixel_total  = total[cmc_pkg::CNT_W-1:0];
		plan_q.insert(plan_q.size(), r);
	endfunction

	// advance the frame state by one pixel; r is the frame result on frame_end
	task automatic track_centroid(input cmc_pkg::pixel_t p, output cmc_pkg::result_t r);
		logic [cmc_pkg::LW_W:0]    next_col;
		logic [cmc_pkg::SUM_W:0]   wide;
		logic [cmc_pkg::SUM_W-1:0] quo;
		r = '0;
		if (p.hue >= hue_lo && p.hue <= hue_hi &&
		    p.saturation >= sat_lo && p.saturation <= sat_hi &&
		    p.brightness >= val_lo && p.brightness <= val_hi &&
		    sel_count != cmc_pkg::COUNT_MAX) begin
			sel_count = sel_count + 1'b1;
			wide      = col_acc + col_pos;
			col_acc   = (wide > cmc_pkg::SUM_MAX) ? cmc_pkg::SUM_MAX : wide[cmc_pkg::SUM_W-1:0];
			wide      = row_acc + row_pos;
			row_acc   = (wide > cmc_pkg::SUM_MAX) ? cmc_pkg::SUM_MAX : wide[cmc_pkg::SUM_W-1:0];
		end
		// raster position: wrap at the line width or the column limit
		next_col = col_pos + 1'b1;
		if (next_col >= row_len || next_col >= COLS) begin
			col_pos = '0;
			if (row_pos < ROWS - 1)
				row_pos = row_pos + 1'b1;
		end else begin
			col_pos = next_col[cmc_pkg::CEN_W-1:0];
		end
		if (p.frame_end) begin
			if (sel_count > count_floor) begin
				quo            = col_acc / sel_count;
				r.centroid_col = quo[cmc_pkg::CEN_W-1:0];
				quo            = row_acc / sel_count;
				r.centroid_row = quo[cmc_pkg::CEN_W-1:0];
				r.found        = 1'b1;
			end
			r.pixel_total = sel_count;
			col_pos   = '0;
			row_pos   = '0;
			sel_count = '0;
			col_acc   = '0;
			row_acc   = '0;
		end
	endtask

	task automatic write_reg(input logic [cmc_pkg::IDX_W-1:0] idx, input int unsigned val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[cmc_pkg::CFG_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			cmc_pkg::REG_HUE_MIN:    hue_lo      = val[cmc_pkg::CH_W-1:0];
			cmc_pkg::REG_HUE_MAX:    hue_hi      = val[cmc_pkg::CH_W-1:0];
			cmc_pkg::REG_SAT_MIN:    sat_lo      = val[cmc_pkg::CH_W-1:0];
			cmc_pkg::REG_SAT_MAX:    sat_hi      = val[cmc_pkg::CH_W-1:0];
			cmc_pkg::REG_VAL_MIN:    val_lo      = val[cmc_pkg::CH_W-1:0];
			cmc_pkg::REG_VAL_MAX:    val_hi      = val[cmc_pkg::CH_W-1:0];
			cmc_pkg::REG_MIN_COUNT:  count_floor = val[cmc_pkg::CNT_W-1:0];
			cmc_pkg::REG_LINE_WIDTH: row_len     = val[cmc_pkg::LW_W-1:0];
			default: ;
		endcase
	endtask

	// offer one pixel request after a random gap, predict it once taken
	task automatic send_pixel(input cmc_pkg::pixel_t p, input bit typed,
		input cmc_pkg::result_t want);
		int unsigned      gap;
		int unsigned      roll;
		cmc_pkg::result_t predicted;
		roll = $urandom_range(0, 99);
		if (burst || roll < 65)
			gap = 0;
		else if (roll < 92)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(8, 30);
		if (gap != 0) begin
			pixel_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel       <= p;
		pixel_valid <= 1'b1;
		@(posedge clk);
		while (pixel_stall) @(posedge clk);
		track_centroid(p, predicted);
		if (p.frame_end)
			centroid_q.insert(centroid_q.size(), typed ? want : predicted);
		pixels_sent++;
	endtask

	// drop valid, let every pending frame come out and the divider go idle
	task automatic wait_quiet();
		pixel_valid <= 1'b0;
		while (centroid_q.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	// channel level: mostly in the window, often on or just past its edges
	function automatic logic [cmc_pkg::CH_W-1:0] pick_level(
		input logic [cmc_pkg::CH_W-1:0] lo, hi);
		int unsigned roll;
		int unsigned level;
		roll = $urandom_range(0, 11);
		if (roll == 0) return lo;
		if (roll == 1) return hi;
		if (roll == 2) return lo - 1'b1;
		if (roll == 3) return hi + 1'b1;
		if (roll < 10 && lo <= hi)
			level = $urandom_range(lo, hi);
		else
			level = $urandom_range(0, 255);
		return level[cmc_pkg::CH_W-1:0];
	endfunction

	task automatic run_frame(input int unsigned len);
		cmc_pkg::pixel_t p;
		for (int unsigned i = 0; i < len; i++) begin
			p.hue        = pick_level(hue_lo, hue_hi);
			p.saturation = pick_level(sat_lo, sat_hi);
			p.brightness = pick_level(val_lo, val_hi);
			p.frame_end  = (i == len - 1);
			send_pixel(p, 1'b0, '0);
		end
	endtask

	// random window for one channel: full, empty or a random span
	task automatic write_bounds(input logic [cmc_pkg::IDX_W-1:0] lo_idx, hi_idx);
		int unsigned roll;
		int unsigned lo;
		int unsigned hi;
		roll = $urandom_range(0, 19);
		if (roll == 0) begin
			lo = 0;
			hi = 255;
		end else if (roll == 1) begin
			lo = $urandom_range(1, 255);
			hi = $urandom_range(0, lo - 1);
		end else begin
			lo = $urandom_range(0, 255);
			hi = $urandom_range(lo, 255);
		end
		write_reg(lo_idx, lo);
		write_reg(hi_idx, hi);
	endtask

	// result checker
	always @(posedge clk) begin
		if (result_valid && !result_stall) begin
			if (centroid_q.size() == 0) begin
				flag_error($sformatf("result with no frame pending, pixel_total %0d",
					result.pixel_total));
			end else begin
				oldest = centroid_q.pop_front();
				if (result.centroid_col !== oldest.centroid_col)
					flag_error($sformatf("centroid_col %0d, expected %0d",
						result.centroid_col, oldest.centroid_col));
				if (result.centroid_row !== oldest.centroid_row)
					flag_error($sformatf("centroid_row %0d, expected %0d",
						result.centroid_row, oldest.centroid_row));
				if (result.found !== oldest.found)
					flag_error($sformatf("found %0d, expected %0d",
						result.found, oldest.found));
				if (result.pixel_total !== oldest.pixel_total)
					flag_error($sformatf("pixel_total %0d, expected %0d",
						result.pixel_total, oldest.pixel_total));
			end
		end
	end

	// output side stalls: short and long holds, calm stretches, one forced hold
	always @(posedge clk) begin
		if (hold_reqs != holds_taken) begin
			holds_taken = hold_reqs;
			stall_left  = HOLD_CYCLES;
		end else if (stall_left == 0) begin
			if (calm_left != 0) begin
				calm_left--;
			end else begin
				stall_roll = $urandom_range(0, 999);
				if (stall_roll < 5)
					calm_left = $urandom_range(100, 300);
				else if (stall_roll < 300)
					stall_left = $urandom_range(1, 3);
				else if (stall_roll < 330)
					stall_left = $urandom_range(10, 40);
			end
		end
		result_stall <= (stall_left != 0);
		if (stall_left != 0)
			stall_left--;
	end

	initial begin : stimulus
		plan_row_t   row;
		bit          was_reg;
		int unsigned phase;
		int unsigned goal;
		int unsigned roll;

		// reset settings: channel extremes, value just below its floor
		plan_want(255, 255, 255, 0, 0, 0, 1);
		plan_want(0, 0, 224, 0, 0, 0, 0);
		// any selected pixel is enough
		plan_reg(cmc_pkg::REG_MIN_COUNT, 0);
		plan_px(0, 0, 225, 1'b0);
		plan_want(128, 128, 255, 0, 0, 1, 2);
		// zero line width: every pixel starts a new row
		plan_reg(cmc_pkg::REG_LINE_WIDTH, 0);
		plan_px(8'h55, 8'hAA, 255, 1'b0);
		plan_px(8'h55, 8'hAA, 255, 1'b0);
		plan_want(8'h55, 8'hAA, 255, 0, 1, 1, 3);
		// count equal to the floor is not found, one more is
		plan_reg(cmc_pkg::REG_LINE_WIDTH, 2);
		plan_reg(cmc_pkg::REG_MIN_COUNT, 2);
		plan_px(1, 2, 255, 1'b0);
		plan_want(3, 4, 255, 0, 0, 0, 2);
		plan_px(1, 2, 255, 1'b0);
		plan_px(1, 2, 255, 1'b0);
		plan_want(1, 2, 255, 0, 0, 1, 3);
		// empty hue window
		plan_reg(cmc_pkg::REG_HUE_MIN, 200);
		plan_reg(cmc_pkg::REG_HUE_MAX, 100);
		plan_reg(cmc_pkg::REG_MIN_COUNT, 0);
		plan_want(150, 0, 255, 0, 0, 0, 0);
		// single saturation level, full value window
		plan_reg(cmc_pkg::REG_HUE_MIN, 0);
		plan_reg(cmc_pkg::REG_HUE_MAX, 255);
		plan_reg(cmc_pkg::REG_SAT_MIN, 255);
		plan_reg(cmc_pkg::REG_SAT_MAX, 255);
		plan_reg(cmc_pkg::REG_VAL_MIN, 0);
		plan_px(0, 254, 0, 1'b0);
		plan_want(0, 255, 0, 1, 0, 1, 1);
		// single hue level across a row wrap
		plan_reg(cmc_pkg::REG_HUE_MIN, 7);
		plan_reg(cmc_pkg::REG_HUE_MAX, 7);
		plan_reg(cmc_pkg::REG_SAT_MIN, 0);
		plan_reg(cmc_pkg::REG_LINE_WIDTH, 3);
		plan_reg(cmc_pkg::REG_MIN_COUNT, 1);
		plan_px(6, 8'h0F, 8'hF0, 1'b0);
		plan_px(7, 8'h0F, 8'hF0, 1'b0);
		plan_px(8, 8'h0F, 8'hF0, 1'b0);
		plan_px(7, 8'h0F, 8'hF0, 1'b0);
		plan_px(7, 8'h0F, 8'hF0, 1'b1);
		// empty value window
		plan_reg(cmc_pkg::REG_VAL_MIN, 10);
		plan_reg(cmc_pkg::REG_VAL_MAX, 9);
		plan_want(7, 0, 9, 0, 0, 0, 0);
		// line width beyond the column limit
		plan_reg(cmc_pkg::REG_VAL_MIN, 0);
		plan_reg(cmc_pkg::REG_VAL_MAX, 255);
		plan_reg(cmc_pkg::REG_HUE_MIN, 0);
		plan_reg(cmc_pkg::REG_HUE_MAX, 255);
		plan_reg(cmc_pkg::REG_LINE_WIDTH, 2047);
		plan_px(255, 255, 255, 1'b0);
		plan_px(0, 0, 0, 1'b0);
		plan_px(7, 255, 128, 1'b1);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		was_reg = 1'b1;
		foreach (plan_q[i]) begin
			row = plan_q[i];
			if (row.is_reg) begin
				if (!was_reg)
					wait_quiet();
				write_reg(row.reg_idx, row.reg_val);
			end else begin
				send_pixel(row.px, row.typed, row.want);
			end
			was_reg = row.is_reg;
		end

		// random phases, new settings between them
		goal  = pixels_sent + RANDOM_ITEMS;
		phase = 0;
		while (pixels_sent < goal) begin
			wait_quiet();
			write_bounds(cmc_pkg::REG_HUE_MIN, cmc_pkg::REG_HUE_MAX);
			write_bounds(cmc_pkg::REG_SAT_MIN, cmc_pkg::REG_SAT_MAX);
			write_bounds(cmc_pkg::REG_VAL_MIN, cmc_pkg::REG_VAL_MAX);
			roll = $urandom_range(0, 9);
			write_reg(cmc_pkg::REG_MIN_COUNT, (roll == 0) ? 0 : (roll == 1) ? 1048576 :
				$urandom_range(0, 20));
			roll = $urandom_range(0, 9);
			write_reg(cmc_pkg::REG_LINE_WIDTH, (roll == 0) ? 1 : (roll == 1) ? 1024 :
				(roll == 2) ? 640 : $urandom_range(1, 12));
			if (phase == 3) begin
				// hold the output for a long stretch while short frames keep coming
				hold_reqs <= hold_reqs + 1;
				burst = 1'b1;
				repeat (20) run_frame($urandom_range(1, 3));
			end else begin
				burst = ($urandom_range(0, 5) == 0);
				repeat ($urandom_range(2, 8))
					run_frame(($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) :
						$urandom_range(1, 24));
			end
			burst = 1'b0;
			phase++;
		end

		wait_quiet();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
